FILE: sv/slc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants of the sorted list with cursor
// Holds the command and status codes, the transaction payload structs and the
// request struct of the entry store.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_FIRST  = 3'd2,
    CMD_LAST   = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_PREV   = 3'd5,
    CMD_READ   = 3'd6
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] cursor_value;
    logic                     cursor_valid;
    logic [CNT_W-1:0]         entry_count;
  } out_item_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: sv/slc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_store: entry store of the sorted list
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module slc_store (
  input  wire logic                             clk,
  input  wire slc_pkg::mem_req_t                req,
  output logic signed [slc_pkg::DATA_W-1:0]     rd_data
);
  import slc_pkg::*;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_r;

  // Read returns the old contents on an address collision.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/sorted_list_with_cursor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_with_cursor_unit: sorted list of signed values with a cursor
// Keeps up to CAPACITY signed 32-bit entries in nondecreasing order in an
// on-chip memory, walked one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command
//   transaction: insert, delete, cursor first/last/next/previous, read.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   result transaction per command: status, entry under the cursor, cursor
//   valid flag and entry count after the command.
//   Cursor and read commands go from acceptance through S_FETCH and
//   S_EMIT to a registered result. Insert and delete scan the memory
//   from entry 0 to the target position and then shift the tail, one
//   entry per cycle through the single read and single write port.
//   One command is in work at a time; in_stall is high until the result
//   is loaded into the output register.
//   A result waiting in the output register does not block the next command;
//   a second result waits in the sequencer until the receiver takes the first.
//   Reset empties the list and invalidates the cursor; memory contents are
//   not cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_list_with_cursor_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire slc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output slc_pkg::out_item_t      out_data
);
  import slc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,   // wait for a command
    S_SCAN,   // search for first entry >= value
    S_UP,     // shift tail up by one for insert
    S_PUT,    // write inserted value
    S_DOWN,   // shift tail down by one for delete
    S_DROP,   // finish delete
    S_FETCH,  // read entry under cursor
    S_EMIT    // load output register
  } state_t;

  state_t                   state_r, state_nxt;
  logic [2:0]               cmd_r, cmd_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         cur_r, cur_nxt;
  logic                     cur_ok_r, cur_ok_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         pos_r, pos_nxt;
  logic [1:0]               status_r, status_nxt;
  out_item_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  mem_req_t                 req;
  logic signed [DATA_W-1:0] rd_data;

  logic [CNT_W-1:0]         cur_ext;
  logic [CNT_W-1:0]         idx_p1, idx_p2, count_m1, scan_pos;
  logic                     ge, scan_stop, accept;

  slc_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign accept   = in_valid && (state_r == S_IDLE);
  assign cur_ext  = CNT_W'(cur_r);
  assign idx_p1   = idx_r + CNT_W'(1);
  assign idx_p2   = idx_r + CNT_W'(2);
  assign count_m1 = count_r - CNT_W'(1);
  assign ge        = (rd_data >= value_r);
  assign scan_stop = ge || (idx_p1 == count_r);
  assign scan_pos  = ge ? idx_r : count_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    cur_ok_nxt    = cur_ok_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    // Default read address tracks the cursor so S_EMIT holds its data.
    req.we        = 1'b0;
    req.waddr     = idx_r[IDX_W-1:0];
    req.wdata     = rd_data;
    req.raddr     = cur_r;

    // Drop the result once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_data.cmd;
          value_nxt  = in_data.value;
          status_nxt = ST_OK;
          state_nxt  = S_FETCH;
          case (in_data.cmd) inside
            CMD_INSERT, CMD_DELETE: begin
              if (in_data.cmd == CMD_INSERT && count_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                pos_nxt = '0;
                if (in_data.cmd == CMD_INSERT) begin
                  state_nxt = S_PUT;
                end else begin
                  status_nxt = ST_MISS;
                end
              end else begin
                idx_nxt   = '0;
                req.raddr = '0;
                state_nxt = S_SCAN;
              end
            end
            CMD_FIRST, CMD_LAST: begin
              if (count_r == '0) begin
                cur_ok_nxt = 1'b0;
                cur_nxt    = '0;
                status_nxt = ST_MISS;
              end else begin
                cur_ok_nxt = 1'b1;
                cur_nxt    = (in_data.cmd == CMD_FIRST) ? '0 : count_m1[IDX_W-1:0];
              end
            end
            CMD_NEXT: begin
              if (!cur_ok_r) begin
                status_nxt = ST_MISS;
              end else if (cur_ext + CNT_W'(1) >= count_r) begin
                cur_ok_nxt = 1'b0;
                cur_nxt    = '0;
              end else begin
                cur_nxt = cur_r + IDX_W'(1);
              end
            end
            CMD_PREV: begin
              if (!cur_ok_r) begin
                status_nxt = ST_MISS;
              end else if (cur_r == '0) begin
                cur_ok_nxt = 1'b0;
              end else begin
                cur_nxt = cur_r - IDX_W'(1);
              end
            end
            CMD_READ: begin
              status_nxt = cur_ok_r ? ST_OK : ST_MISS;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // rd_data holds entry idx_r here.
        if (scan_stop) begin
          pos_nxt = scan_pos;
          if (cmd_r == CMD_INSERT) begin
            if (scan_pos == count_r) begin
              state_nxt = S_PUT;
            end else begin
              idx_nxt   = count_r;
              req.raddr = count_m1[IDX_W-1:0];
              state_nxt = S_UP;
            end
          end else if (!(ge && rd_data == value_r)) begin
            status_nxt = ST_MISS;
            state_nxt  = S_FETCH;
          end else if (idx_p1 == count_r) begin
            state_nxt = S_DROP;
          end else begin
            req.raddr = idx_p1[IDX_W-1:0];
            state_nxt = S_DOWN;
          end
        end else begin
          idx_nxt   = idx_p1;
          req.raddr = idx_p1[IDX_W-1:0];
        end
      end

      S_UP: begin
        // Move entry idx_r-1 to idx_r, prefetch the one below it.
        req.we    = 1'b1;
        req.waddr = idx_r[IDX_W-1:0];
        req.wdata = rd_data;
        idx_nxt   = idx_r - CNT_W'(1);
        req.raddr = idx_nxt[IDX_W-1:0] - IDX_W'(1);
        if (idx_nxt == pos_r) begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        req.we    = 1'b1;
        req.waddr = pos_r[IDX_W-1:0];
        req.wdata = value_r;
        count_nxt = count_r + CNT_W'(1);
        if (cur_ok_r && cur_ext >= pos_r) begin
          cur_nxt = cur_r + IDX_W'(1);
        end
        state_nxt = S_FETCH;
      end

      S_DOWN: begin
        // Move entry idx_r+1 to idx_r, prefetch the one after it.
        req.we    = 1'b1;
        req.waddr = idx_r[IDX_W-1:0];
        req.wdata = rd_data;
        idx_nxt   = idx_p1;
        req.raddr = idx_p2[IDX_W-1:0];
        if (idx_p2 == count_r) begin
          state_nxt = S_DROP;
        end
      end

      S_DROP: begin
        count_nxt = count_m1;
        if (cur_ok_r) begin
          if (cur_ext == pos_r) begin
            cur_ok_nxt = 1'b0;
            cur_nxt    = '0;
          end else if (cur_ext > pos_r) begin
            cur_nxt = cur_r - IDX_W'(1);
          end
        end
        state_nxt = S_FETCH;
      end

      S_FETCH: begin
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // Hold here while a previous result is still stalled.
        if (!out_valid_r || !out_stall) begin
          out_nxt.status       = status_r;
          out_nxt.cursor_value = cur_ok_r ? rd_data : '0;
          out_nxt.cursor_valid = cur_ok_r;
          out_nxt.entry_count  = count_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      cur_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      cur_ok_r    <= cur_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    value_r  <= value_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
